@@ design/tpcrt_pkg.sv @@
// Package for the two-phase capacity reservation table unit.
// Types, op and status codes shared by the front, back and top-level modules.
// No dependencies.
`default_nettype none
package tpcrt_pkg;

  localparam int unsigned TableDepthDef = 16;
  localparam int unsigned IdWidthDef    = 32;
  localparam int unsigned CfgIdxW       = 1;
  localparam int unsigned CfgDataW      = 32;

  typedef enum logic [2:0] {
    OP_BEGIN    = 3'd0,
    OP_COMMIT   = 3'd1,
    OP_ROLLBACK = 3'd2,
    OP_RELEASE  = 3'd3,
    OP_LOOKUP   = 3'd4
  } op_e;

  typedef enum logic [3:0] {
    ST_OK        = 4'd0,
    ST_BUSY      = 4'd1,
    ST_ZERO_COST = 4'd2,
    ST_DUPLICATE = 4'd3,
    ST_IDS_EXH   = 4'd4,
    ST_NO_CAP    = 4'd5,
    ST_TBL_FULL  = 4'd6,
    ST_NOT_FOUND = 4'd7,
    ST_NO_TENT   = 4'd8
  } status_e;

  localparam logic [CfgIdxW-1:0] CFG_SEQ_CAP = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_KV_CAP  = 1'b1;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] request_id;
    logic [15:0] seq_cost;
    logic [31:0] kv_cost;
    logic [31:0] reservation_id;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [31:0] granted_id;
    logic        found;
    logic [15:0] found_seq_cost;
    logic [31:0] found_kv_cost;
    logic [15:0] seq_in_use;
    logic [31:0] kv_in_use;
    logic [4:0]  live_count;
  } out_item_t;

  // Front-end classification handed to the back end with the item.
  typedef struct packed {
    logic     zero_cost;
    logic     known_op;
    in_item_t item;
  } cls_item_t;

  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_SCAN = 2'd1,
    BK_EXEC = 2'd2,
    BK_OUT  = 2'd3
  } bk_state_e;

endpackage
`default_nettype wire

@@ design/tpcrt_front.sv @@
// Front end: takes input items, classifies them and loads a two-entry queue.
// Depends on tpcrt_pkg.
`default_nettype none
module tpcrt_front (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_push,
  input  tpcrt_pkg::in_item_t   in_data,
  output logic                  in_full,
  output tpcrt_pkg::cls_item_t  q_data,
  output logic                  q_valid,
  input  wire                   q_take
);
  import tpcrt_pkg::*;

  cls_item_t  buf_r [2];
  logic       rd_r, rd_nxt, wr_r, wr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  cls_item_t  cls;
  logic       do_push, do_pop;

  // classify
  always_comb begin
    cls.item      = in_data;
    cls.zero_cost = (in_data.seq_cost == '0) || (in_data.kv_cost == '0);
    cls.known_op  = (in_data.op <= OP_LOOKUP);
  end

  assign in_full = (cnt_r == 2'd2);
  assign do_push = in_push && !in_full;
  assign q_valid = (cnt_r != 2'd0);
  assign do_pop  = q_take && q_valid;
  assign q_data  = buf_r[rd_r];

  always_comb begin
    rd_nxt  = rd_r ^ do_pop;
    wr_nxt  = wr_r ^ do_push;
    cnt_nxt = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      rd_r  <= rd_nxt;
      wr_r  <= wr_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      buf_r[wr_r] <= cls;
    end
  end

`ifndef SYNTHESIS
  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("front queue count out of range");
  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> cnt_r == $past(cnt_r) + 2'd1)
    else $error("front queue count did not grow");
  a_pop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (do_pop && !do_push) |=> cnt_r == $past(cnt_r) - 2'd1)
    else $error("front queue count did not shrink");
`endif
endmodule
`default_nettype wire

@@ design/tpcrt_back.sv @@
// Back end: scans the reservation table one slot a cycle, then applies the op.
// Depends on tpcrt_pkg.
`default_nettype none
module tpcrt_back #(
  parameter int unsigned TABLE_DEPTH = tpcrt_pkg::TableDepthDef,
  parameter int unsigned ID_WIDTH    = tpcrt_pkg::IdWidthDef
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  tpcrt_pkg::cls_item_t  q_data,
  input  wire                   q_valid,
  output logic                  q_take,
  input  wire  [15:0]           seq_cap,
  input  wire  [31:0]           kv_cap,
  output logic                  out_empty,
  input  wire                   out_pop,
  output tpcrt_pkg::out_item_t  out_data
);
  import tpcrt_pkg::*;

  localparam int unsigned SW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [ID_WIDTH-1:0] IdOnes = '1;

  // table storage; valid/committed cleared by reset, payload written on begin
  logic [TABLE_DEPTH-1:0] vld_r, cmt_r;
  logic [31:0]       req_r  [TABLE_DEPTH];
  logic [ID_WIDTH-1:0] id_r [TABLE_DEPTH];
  logic [15:0]       sc_r   [TABLE_DEPTH];
  logic [31:0]       kc_r   [TABLE_DEPTH];

  logic              tl_r;
  logic [SW-1:0]     ts_r;
  logic [ID_WIDTH-1:0] nid_r;
  logic [15:0]       su_r;
  logic [31:0]       ku_r;
  logic [CW-1:0]     live_r;

  bk_state_e         st_r, st_nxt;
  cls_item_t         it_r;
  logic [SW-1:0]     idx_r;
  logic              dup_r, hit_r, free_r;
  logic [SW-1:0]     hk_r, fs_r;
  out_item_t         res_r;
  logic              res_v_r;

  logic scan_last;
  assign scan_last = (idx_r == SW'(TABLE_DEPTH - 1));

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      BK_IDLE: if (q_valid) st_nxt = BK_SCAN;
      BK_SCAN: if (scan_last) st_nxt = BK_EXEC;
      BK_EXEC: st_nxt = BK_OUT;
      BK_OUT:  if (!res_v_r || out_pop) st_nxt = BK_IDLE;
      default: st_nxt = BK_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    q_take = (st_r == BK_IDLE) && q_valid;
  end

  assign out_empty = !res_v_r;
  assign out_data  = res_r;

  // op execution terms
  logic [16:0] seq_sum;
  logic [32:0] kv_sum;
  logic [ID_WIDTH-1:0] nid_ext;
  always_comb begin
    seq_sum = {1'b0, su_r} + {1'b0, it_r.item.seq_cost};
    kv_sum  = {1'b0, ku_r} + {1'b0, it_r.item.kv_cost};
    nid_ext = nid_r;
  end

  logic [16:0] c_seq;
  logic [32:0] c_kv;
  always_comb begin
    c_seq = {1'b0, su_r} + {1'b0, sc_r[ts_r]};
    c_kv  = {1'b0, ku_r} + {1'b0, kc_r[ts_r]};
  end

  // saturated totals after a commit or a release
  logic [15:0] seq_cm, seq_rl;
  logic [31:0] kv_cm, kv_rl;
  always_comb begin
    seq_cm = c_seq[16] ? 16'hFFFF : c_seq[15:0];
    kv_cm  = c_kv[32] ? 32'hFFFF_FFFF : c_kv[31:0];
    seq_rl = (su_r >= sc_r[hk_r]) ? su_r - sc_r[hk_r] : '0;
    kv_rl  = (ku_r >= kc_r[hk_r]) ? ku_r - kc_r[hk_r] : '0;
  end

  // result of the op in the execute cycle
  out_item_t res_nxt;
  always_comb begin
    res_nxt            = '0;
    res_nxt.status     = ST_OK;
    res_nxt.seq_in_use = su_r;
    res_nxt.kv_in_use  = ku_r;
    res_nxt.live_count = 5'(live_r);
    if (it_r.known_op) begin
      unique case (op_e'(it_r.item.op))
        OP_BEGIN: begin
          priority if (tl_r) res_nxt.status = ST_BUSY;
          else if (it_r.zero_cost) res_nxt.status = ST_ZERO_COST;
          else if (dup_r) res_nxt.status = ST_DUPLICATE;
          else if (nid_r == IdOnes) res_nxt.status = ST_IDS_EXH;
          else if (seq_sum > {1'b0, seq_cap} || kv_sum > {1'b0, kv_cap})
            res_nxt.status = ST_NO_CAP;
          else if (!free_r) res_nxt.status = ST_TBL_FULL;
          else res_nxt.granted_id = 32'(nid_ext);
        end
        OP_COMMIT: begin
          if (!tl_r) res_nxt.status = ST_NO_TENT;
          else begin
            res_nxt.seq_in_use = seq_cm;
            res_nxt.kv_in_use  = kv_cm;
            res_nxt.live_count = 5'(live_r + CW'(1));
            res_nxt.granted_id = 32'(id_r[ts_r]);
          end
        end
        OP_ROLLBACK: begin
          if (!tl_r) res_nxt.status = ST_NO_TENT;
        end
        OP_RELEASE: begin
          if (!hit_r) res_nxt.status = ST_NOT_FOUND;
          else begin
            res_nxt.seq_in_use = seq_rl;
            res_nxt.kv_in_use  = kv_rl;
            res_nxt.live_count = 5'(live_r - CW'(1));
          end
        end
        OP_LOOKUP: begin
          if (!hit_r) res_nxt.status = ST_NOT_FOUND;
          else begin
            res_nxt.found          = 1'b1;
            res_nxt.found_seq_cost = sc_r[hk_r];
            res_nxt.found_kv_cost  = kc_r[hk_r];
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= BK_IDLE;
      vld_r   <= '0;
      cmt_r   <= '0;
      tl_r    <= 1'b0;
      ts_r    <= '0;
      nid_r   <= ID_WIDTH'(1);
      su_r    <= '0;
      ku_r    <= '0;
      live_r  <= '0;
      res_v_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      st_r <= st_nxt;
      if (res_v_r && out_pop) res_v_r <= 1'b0;
      if (q_take) begin
        it_r   <= q_data;
        idx_r  <= '0;
        dup_r  <= 1'b0;
        hit_r  <= 1'b0;
        free_r <= 1'b0;
      end
      // one slot per cycle: duplicate, committed-id match, lowest free
      if (st_r == BK_SCAN) begin
        idx_r <= idx_r + SW'(1);
        if (vld_r[idx_r] && req_r[idx_r] == it_r.item.request_id) dup_r <= 1'b1;
        if (vld_r[idx_r] && cmt_r[idx_r] && !hit_r &&
            id_r[idx_r] == ID_WIDTH'(it_r.item.reservation_id)) begin
          hit_r <= 1'b1;
          hk_r  <= idx_r;
        end
        if (!vld_r[idx_r] && !free_r) begin
          free_r <= 1'b1;
          fs_r   <= idx_r;
        end
      end
      // apply the op when it succeeded
      if (st_r == BK_EXEC) begin
        res_v_r <= 1'b1;
        res_r   <= res_nxt;
        if (it_r.known_op && res_nxt.status == ST_OK) begin
          unique case (op_e'(it_r.item.op))
            OP_BEGIN: begin
              vld_r[fs_r] <= 1'b1;
              cmt_r[fs_r] <= 1'b0;
              req_r[fs_r] <= it_r.item.request_id;
              id_r[fs_r]  <= nid_r;
              sc_r[fs_r]  <= it_r.item.seq_cost;
              kc_r[fs_r]  <= it_r.item.kv_cost;
              tl_r        <= 1'b1;
              ts_r        <= fs_r;
            end
            OP_COMMIT: begin
              su_r        <= seq_cm;
              ku_r        <= kv_cm;
              cmt_r[ts_r] <= 1'b1;
              tl_r        <= 1'b0;
              live_r      <= live_r + CW'(1);
              nid_r       <= nid_r + ID_WIDTH'(1);
            end
            OP_ROLLBACK: begin
              vld_r[ts_r] <= 1'b0;
              cmt_r[ts_r] <= 1'b0;
              tl_r        <= 1'b0;
            end
            OP_RELEASE: begin
              su_r        <= seq_rl;
              ku_r        <= kv_rl;
              vld_r[hk_r] <= 1'b0;
              cmt_r[hk_r] <= 1'b0;
              live_r      <= live_r - CW'(1);
            end
            OP_LOOKUP: ;
            default: ;
          endcase
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_live_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    live_r == CW'($countones(vld_r & cmt_r))) else $error("live count drift");
  a_tent_valid: assert property (@(posedge clk) disable iff (!rst_n)
    tl_r |-> (vld_r[ts_r] && !cmt_r[ts_r])) else $error("tentative slot lost");
  a_cmt_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (cmt_r & ~vld_r) == '0) else $error("committed entry not valid");
  a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_take |=> st_r == BK_SCAN) else $error("take without scan");
`endif
endmodule
`default_nettype wire

@@ design/two_phase_capacity_reservation_table_unit.sv @@
// Channel  | dir | handshake         | payload
// in       | in  | in_push / in_full  | in_data  (in_item_t)
// out      | out | out_pop / out_empty| out_data (out_item_t)
// cfg      | in  | cfg_we             | cfg_idx, cfg_wdata
// In the back end, each item is taken from the queue, then one slot of the
// table is scanned per cycle, then the op executes, then the result
// is held. A two-entry queue in front keeps accepting while the back end works.
// rst_n is synchronous; it clears valid bits, totals and next id (to 1).
// A result waiting on out_pop stalls the back end; the front fills and raises full.
// Top level; depends on tpcrt_pkg, tpcrt_front, tpcrt_back.
`default_nettype none
module two_phase_capacity_reservation_table_unit #(
  parameter int unsigned TABLE_DEPTH = tpcrt_pkg::TableDepthDef,
  parameter int unsigned ID_WIDTH    = tpcrt_pkg::IdWidthDef
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  in_push,
  output logic                                 in_full,
  input  tpcrt_pkg::in_item_t                  in_data,
  output logic                                 out_empty,
  input  wire                                  out_pop,
  output tpcrt_pkg::out_item_t                 out_data,
  input  wire                                  cfg_we,
  input  wire  [tpcrt_pkg::CfgIdxW-1:0]        cfg_idx,
  input  wire  [tpcrt_pkg::CfgDataW-1:0]       cfg_wdata
);
  import tpcrt_pkg::*;

  logic [15:0] seq_cap_r;
  logic [31:0] kv_cap_r;
  cls_item_t   q_data;
  logic        q_valid, q_take;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_cap_r <= '0;
      kv_cap_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_SEQ_CAP: seq_cap_r <= cfg_wdata[15:0];
        CFG_KV_CAP:  kv_cap_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  tpcrt_front u_front (
    .clk(clk), .rst_n(rst_n), .in_push(in_push), .in_data(in_data),
    .in_full(in_full), .q_data(q_data), .q_valid(q_valid), .q_take(q_take)
  );

  tpcrt_back #(.TABLE_DEPTH(TABLE_DEPTH), .ID_WIDTH(ID_WIDTH)) u_back (
    .clk(clk), .rst_n(rst_n), .q_data(q_data), .q_valid(q_valid),
    .q_take(q_take), .seq_cap(seq_cap_r), .kv_cap(kv_cap_r),
    .out_empty(out_empty), .out_pop(out_pop), .out_data(out_data)
  );
endmodule
`default_nettype wire

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the two-phase capacity reservation table unit.
// Directed table, then random begin/commit/rollback/release/lookup traffic,
// all scored against an in-bench model; depends on tpcrt_pkg and the unit.
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import tpcrt_pkg::*;

  localparam int Depth = 16;
  localparam longint CycleLimit = 2000000;

  logic clk, rst_n;
  logic in_push, in_full, out_empty, out_pop, cfg_we;
  in_item_t in_data;
  out_item_t out_data;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [CfgDataW-1:0] cfg_wdata;

  two_phase_capacity_reservation_table_unit dut (
    .clk(clk), .rst_n(rst_n), .in_push(in_push), .in_full(in_full), .in_data(in_data),
    .out_empty(out_empty), .out_pop(out_pop), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  // Model state of the admission table
  logic [15:0] m_seq_cap;
  logic [31:0] m_kv_cap;
  logic        m_valid [Depth];
  logic        m_comm [Depth];
  logic [31:0] m_req [Depth];
  logic [31:0] m_id [Depth];
  logic [15:0] m_sc [Depth];
  logic [31:0] m_kc [Depth];
  logic        m_tent;
  logic [3:0]  m_tslot;
  logic [31:0] m_next_id;
  logic [15:0] m_seq_used;
  logic [31:0] m_kv_used;

  out_item_t pending_results[$];
  int errors = 0;
  int mismatches = 0;
  longint cycles = 0;
  bit hold_off = 0;
  bit long_hold = 0;
  int hold_count = 0;
  int pop_gap = 0;

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // Run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic int find_committed(logic [31:0] rid);
    for (int i = 0; i < Depth; i++)
      if (m_valid[i] && m_comm[i] && m_id[i] == rid) return i;
    return -1;
  endfunction

  // Compute expected result and advance model state
  function automatic out_item_t admit_step(in_item_t it);
    out_item_t r;
    int k, slot;
    bit dup;
    logic [16:0] s17;
    logic [32:0] k33;
    r = '0;
    r.status = ST_OK;
    case (it.op)
      OP_BEGIN: begin
        dup = 0;
        slot = -1;
        for (int i = 0; i < Depth; i++) if (m_valid[i] && m_req[i] == it.request_id) dup = 1;
        for (int i = Depth - 1; i >= 0; i--) if (!m_valid[i]) slot = i;
        if (m_tent) r.status = ST_BUSY;
        else if (it.seq_cost == 0 || it.kv_cost == 0) r.status = ST_ZERO_COST;
        else if (dup) r.status = ST_DUPLICATE;
        else if (m_next_id == 32'hFFFF_FFFF) r.status = ST_IDS_EXH;
        else if ({1'b0, m_seq_used} + it.seq_cost > {1'b0, m_seq_cap} ||
                 {1'b0, m_kv_used} + it.kv_cost > {1'b0, m_kv_cap}) r.status = ST_NO_CAP;
        else if (slot < 0) r.status = ST_TBL_FULL;
        else begin
          m_valid[slot] = 1; m_comm[slot] = 0;
          m_req[slot] = it.request_id; m_id[slot] = m_next_id;
          m_sc[slot] = it.seq_cost; m_kc[slot] = it.kv_cost;
          m_tent = 1; m_tslot = slot[3:0];
          r.granted_id = m_next_id;
        end
      end
      OP_COMMIT: begin
        if (!m_tent) r.status = ST_NO_TENT;
        else begin
          s17 = {1'b0, m_seq_used} + m_sc[m_tslot];
          m_seq_used = s17[16] ? 16'hFFFF : s17[15:0];
          k33 = {1'b0, m_kv_used} + m_kc[m_tslot];
          m_kv_used = k33[32] ? 32'hFFFF_FFFF : k33[31:0];
          m_comm[m_tslot] = 1; m_tent = 0;
          r.granted_id = m_id[m_tslot];
          m_next_id = m_next_id + 1;
        end
      end
      OP_ROLLBACK: begin
        if (!m_tent) r.status = ST_NO_TENT;
        else begin
          m_valid[m_tslot] = 0; m_comm[m_tslot] = 0; m_tent = 0;
        end
      end
      OP_RELEASE: begin
        k = find_committed(it.reservation_id);
        if (k < 0) r.status = ST_NOT_FOUND;
        else begin
          m_seq_used = m_seq_used >= m_sc[k] ? m_seq_used - m_sc[k] : 16'd0;
          m_kv_used = m_kv_used >= m_kc[k] ? m_kv_used - m_kc[k] : 32'd0;
          m_valid[k] = 0; m_comm[k] = 0;
        end
      end
      OP_LOOKUP: begin
        k = find_committed(it.reservation_id);
        if (k < 0) r.status = ST_NOT_FOUND;
        else begin
          r.found = 1; r.found_seq_cost = m_sc[k]; r.found_kv_cost = m_kc[k];
        end
      end
      default: ;
    endcase
    r.seq_in_use = m_seq_used;
    r.kv_in_use = m_kv_used;
    for (int i = 0; i < Depth; i++) if (m_valid[i] && m_comm[i]) r.live_count++;
    return r;
  endfunction

  // Result side: random pop gaps, one long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 0;
    end else begin
      if (!out_empty && out_pop) begin
        if (pending_results.size() == 0) begin
          errors++;
          if (mismatches++ < 10) $display("unexpected result %h", out_data);
        end else begin
          if (out_data !== pending_results[0]) begin
            errors++;
            if (mismatches++ < 10)
              $display("mismatch exp %h got %h", pending_results[0], out_data);
          end
          void'(pending_results.pop_front());
        end
      end
      if (long_hold && hold_count < 400) begin
        hold_count <= hold_count + 1;
        out_pop <= 0;
      end else if (hold_off) begin
        out_pop <= ($urandom_range(0, 3) != 0);
      end else if (pop_gap > 0) begin
        pop_gap <= pop_gap - 1;
        out_pop <= 0;
      end else if ($urandom_range(0, 4) == 0) begin
        // mostly short gaps, now and then a long one
        pop_gap <= ($urandom_range(0, 19) == 0) ? $urandom_range(10, 50) : $urandom_range(0, 3);
        out_pop <= 0;
      end else begin
        out_pop <= 1;
      end
    end
  end

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1; cfg_idx <= idx; cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 0;
    if (idx == CFG_SEQ_CAP) m_seq_cap = val[15:0];
    else m_kv_cap = val;
  endtask

  task automatic drain_results();
    in_push <= 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  // Offer one item, hold until accepted, then predict; push stays high after
  // the transfer so the next item may follow back to back
  task automatic push_item(in_item_t it);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_push <= 0;
      repeat (gap) @(posedge clk);
    end
    in_push <= 1; in_data <= it;
    do @(posedge clk); while (in_full);
    pending_results.push_back(admit_step(it));
  endtask

  function automatic in_item_t mk(logic [2:0] op, logic [31:0] req, logic [15:0] sc,
                                  logic [31:0] kc, logic [31:0] rid);
    in_item_t it;
    it.op = op; it.request_id = req; it.seq_cost = sc; it.kv_cost = kc; it.reservation_id = rid;
    return it;
  endfunction

  // Pick a reservation id that often names an entry in the table
  function automatic logic [31:0] pick_rid();
    int i;
    i = $urandom_range(0, Depth - 1);
    if ($urandom_range(0, 4) != 0 && m_valid[i]) return m_id[i];
    return ($urandom_range(0, 1)) ? $urandom : $urandom_range(0, 40);
  endfunction

  typedef struct {
    in_item_t   item;
    bit         typed;
    logic [3:0] status;
  } directed_row_t;

  directed_row_t rows[$];
  logic [31:0] req_base;

  initial begin
    rst_n = 0; in_push = 0; in_data = '0; cfg_we = 0; cfg_idx = '0; cfg_wdata = '0;
    for (int i = 0; i < Depth; i++) begin
      m_valid[i] = 0; m_comm[i] = 0; m_req[i] = 0; m_id[i] = 0; m_sc[i] = 0; m_kc[i] = 0;
    end
    m_tent = 0; m_tslot = 0; m_next_id = 1; m_seq_used = 0; m_kv_used = 0;
    m_seq_cap = 0; m_kv_cap = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Zero capacity after reset: any begin with nonzero costs fails for capacity
    rows.push_back('{mk(OP_COMMIT, 0, 0, 0, 0), 1, ST_NO_TENT});
    rows.push_back('{mk(OP_ROLLBACK, 0, 0, 0, 0), 1, ST_NO_TENT});
    rows.push_back('{mk(OP_BEGIN, 7, 0, 5, 0), 1, ST_ZERO_COST});
    rows.push_back('{mk(OP_BEGIN, 7, 5, 0, 0), 1, ST_ZERO_COST});
    rows.push_back('{mk(OP_BEGIN, 7, 1, 1, 0), 1, ST_NO_CAP});
    rows.push_back('{mk(OP_LOOKUP, 0, 0, 0, 1), 1, ST_NOT_FOUND});
    rows.push_back('{mk(OP_RELEASE, 0, 0, 0, 32'hFFFF_FFFF), 1, ST_NOT_FOUND});
    rows.push_back('{mk(3'd5, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 1, ST_OK});
    rows.push_back('{mk(3'd7, 0, 0, 0, 0), 1, ST_OK});
    foreach (rows[i]) begin
      push_item(rows[i].item);
      if (rows[i].typed && pending_results[$].status != rows[i].status) begin
        errors++;
        $display("directed row %0d predicted %0d typed %0d", i,
                 pending_results[$].status, rows[i].status);
      end
    end
    drain_results();

    // Max capacities: begin, busy, commit, duplicate, no capacity, lookup, release, no tentative, full table
    write_reg(CFG_SEQ_CAP, 32'h0000_FFFF);
    write_reg(CFG_KV_CAP, 32'hFFFF_FFFF);
    push_item(mk(OP_BEGIN, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 0));
    push_item(mk(OP_BEGIN, 1, 1, 1, 0));
    push_item(mk(OP_COMMIT, 0, 0, 0, 0));
    push_item(mk(OP_BEGIN, 32'hFFFF_FFFF, 1, 1, 0));
    push_item(mk(OP_BEGIN, 2, 1, 1, 0));
    push_item(mk(OP_LOOKUP, 0, 0, 0, 1));
    push_item(mk(OP_RELEASE, 0, 0, 0, 1));
    push_item(mk(OP_ROLLBACK, 0, 0, 0, 0));
    for (int i = 0; i < Depth + 1; i++) begin
      push_item(mk(OP_BEGIN, 100 + i, 1, 1, 0));
      push_item(mk(OP_COMMIT, 0, 0, 0, 0));
    end
    drain_results();

    // Random phases over several capacity settings
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin write_reg(CFG_SEQ_CAP, 64); write_reg(CFG_KV_CAP, 5000); end
        1: begin write_reg(CFG_SEQ_CAP, 16'hFFFF); write_reg(CFG_KV_CAP, 32'hFFFF_FFFF); end
        2: begin write_reg(CFG_SEQ_CAP, 0); write_reg(CFG_KV_CAP, 0); end
        3: begin write_reg(CFG_SEQ_CAP, $urandom_range(1, 300));
                 write_reg(CFG_KV_CAP, $urandom); end
        default: begin write_reg(CFG_SEQ_CAP, $urandom); write_reg(CFG_KV_CAP, $urandom); end
      endcase
      // Long receiver hold-off during one phase fills the input queue
      if (ph == 1) begin long_hold = 1; end
      hold_off = (ph == 4);
      req_base = $urandom;
      for (int n = 0; n < 150; n++) begin
        case ($urandom_range(0, 9))
          0, 1, 2: push_item(mk(OP_BEGIN,
                      ($urandom_range(0, 3) == 0) ? $urandom : req_base + $urandom_range(0, 30),
                      16'(($urandom_range(0, 9) == 0) ? 0 :
                        (($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(1, 20))),
                      ($urandom_range(0, 9) == 0) ? 32'd0 :
                        (($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(1, 900)),
                      $urandom));
          3, 4: push_item(mk(OP_COMMIT, $urandom, 16'($urandom), $urandom, $urandom));
          5: push_item(mk(OP_ROLLBACK, $urandom, 16'($urandom), $urandom, $urandom));
          6, 7: push_item(mk(OP_RELEASE, $urandom, 16'($urandom), $urandom, pick_rid()));
          8: push_item(mk(OP_LOOKUP, $urandom, 16'($urandom), $urandom, pick_rid()));
          default: push_item(mk(3'($urandom_range(0, 7)), $urandom, 16'($urandom), $urandom,
                                pick_rid()));
        endcase
      end
      long_hold = 0;
      // Sender pauses until every result has come back
      drain_results();
    end

    drain_results();
    if (errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule
`default_nettype wire

@@ sim.f @@
design/tpcrt_pkg.sv
design/tpcrt_front.sv
design/tpcrt_back.sv
design/two_phase_capacity_reservation_table_unit.sv
tb/sv/testbench.sv
